FILE: hw/rtl/sap_pkg.sv
// Shared types, codes and constants for the stepper axis positioner.
// No dependencies; every other file of the block refers to this package.
package sap_pkg;

  // Fixed field widths of the request and result channels.
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned COIL_W   = 4;
  localparam int unsigned PHASE_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Default parameter values.
  localparam int unsigned DEF_POS_WIDTH   = 16;
  localparam int unsigned DEF_TIMER_WIDTH = 16;

  // Request opcodes (the unused code behaves as a tick).
  localparam logic [OPCODE_W-1:0] OP_TICK = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_GOTO = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_HOME = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOME_GAP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COIL_TABLE  = 2'd2;

  // Configuration reset values.
  localparam logic [FIELD_W-1:0] RST_HALF_PERIOD = 16'd65;
  localparam logic [FIELD_W-1:0] RST_HOME_GAP    = 16'd250;
  localparam logic [FIELD_W-1:0] RST_COIL_TABLE  = 16'h9A65;

  // Axis mode codes.
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_GOTO = 2'd1;
  localparam logic [1:0] MODE_HOME = 2'd2;

  // Sub-step codes within one step.
  localparam logic [1:0] SUB_ENERGIZED = 2'd0;
  localparam logic [1:0] SUB_OFF       = 2'd1;
  localparam logic [1:0] SUB_GAP       = 2'd2;

  // Phase given by the first step after reset.
  localparam logic [PHASE_W-1:0] PHASE_FRESH_FWD = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_FRESH_BWD = 2'd3;

  // Configuration register set.
  typedef struct packed {
    logic [FIELD_W-1:0] half_period;
    logic [FIELD_W-1:0] home_gap;
    logic [FIELD_W-1:0] coil_table;
  } sap_cfg_t;

  // One result item.
  typedef struct packed {
    logic [COIL_W-1:0]         coil_drive;
    logic signed [FIELD_W-1:0] current_position;
    logic                      busy_res;
    logic                      command_ignored;
  } sap_result_t;

endpackage

FILE: hw/rtl/sap_in_if.sv
// Request channel interface of the stepper axis positioner.
// Depends on sap_pkg for the field widths.
interface sap_in_if;
  logic                               valid;
  logic                               ready;
  logic [sap_pkg::OPCODE_W-1:0]       opcode;
  logic signed [sap_pkg::FIELD_W-1:0] target_position;
  logic                               limit_switch;

  modport source (output valid, opcode, target_position, limit_switch, input ready);
  modport sink   (input valid, opcode, target_position, limit_switch, output ready);
endinterface

FILE: hw/rtl/sap_out_if.sv
// Result channel interface of the stepper axis positioner.
// Depends on sap_pkg for the field widths.
interface sap_out_if;
  logic                               valid;
  logic                               ready;
  logic [sap_pkg::COIL_W-1:0]         coil_drive;
  logic signed [sap_pkg::FIELD_W-1:0] current_position;
  logic                               busy_res;
  logic                               command_ignored;

  modport source (output valid, coil_drive, current_position, busy_res, command_ignored,
                  input ready);
  modport sink   (input valid, coil_drive, current_position, busy_res, command_ignored,
                  output ready);
endinterface

FILE: hw/rtl/sap_cfg_regs.sv
// Configuration register file: half period, homing gap and coil table.
// Depends on sap_pkg for the register indexes, reset values and struct.
module sap_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sap_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sap_pkg::FIELD_W-1:0]     cfg_data,
  output sap_pkg::sap_cfg_t               cfg
);

  sap_pkg::sap_cfg_t cfg_r;

  // Write one register per enabled cycle; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period <= sap_pkg::RST_HALF_PERIOD;
      cfg_r.home_gap    <= sap_pkg::RST_HOME_GAP;
      cfg_r.coil_table  <= sap_pkg::RST_COIL_TABLE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sap_pkg::CFG_HALF_PERIOD: cfg_r.half_period <= cfg_data;
        sap_pkg::CFG_HOME_GAP:    cfg_r.home_gap    <= cfg_data;
        sap_pkg::CFG_COIL_TABLE:  cfg_r.coil_table  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/sap_axis_core.sv
// Axis state (phase, position, goal, mode, sub-step, timer) and its update
// for one request; also forms the result. Depends on sap_pkg.
module sap_axis_core #(
  parameter int unsigned POS_WIDTH   = sap_pkg::DEF_POS_WIDTH,
  parameter int unsigned TIMER_WIDTH = sap_pkg::DEF_TIMER_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               fire,
  input  logic [sap_pkg::OPCODE_W-1:0]       opcode,
  input  logic signed [sap_pkg::FIELD_W-1:0] target_position,
  input  logic                               limit_switch,
  input  sap_pkg::sap_cfg_t                  cfg,
  output sap_pkg::sap_result_t               result
);

  localparam int unsigned FW    = sap_pkg::FIELD_W;
  // Common width for comparing 16-bit fields with the parameterized ones.
  localparam int unsigned EXT_W = (POS_WIDTH > FW) ? POS_WIDTH : FW;
  localparam int unsigned TEX_W = (TIMER_WIDTH > FW) ? TIMER_WIDTH : FW;

  localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};
  localparam logic signed [EXT_W-1:0] POS_MAX_X = EXT_W'(POS_MAX);
  localparam logic signed [EXT_W-1:0] POS_MIN_X = EXT_W'(POS_MIN);
  localparam logic [TEX_W-1:0] TMR_MAX_X = TEX_W'({TIMER_WIDTH{1'b1}});

  logic [sap_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic                        fresh_r, fresh_nxt;
  logic signed [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic signed [POS_WIDTH-1:0] goal_r, goal_nxt;
  logic [1:0]                  mode_r, mode_nxt;
  logic [1:0]                  sub_r, sub_nxt;
  logic [TIMER_WIDTH-1:0]      timer_r, timer_nxt;

  logic signed [EXT_W-1:0]     target_x;
  logic signed [POS_WIDTH-1:0] target_clamped;
  logic [TEX_W-1:0]            hp_x, gap_x;
  logic [TIMER_WIDTH-1:0]      hp_load, gap_load;
  logic [TIMER_WIDTH-1:0]      timer_dec;
  logic                        do_step, step_fwd, ignored;
  logic signed [EXT_W-1:0]     pos_ext;

  // Goal clamped to the position range.
  always_comb begin
    target_x = EXT_W'(target_position);
    if (target_x > POS_MAX_X) begin
      target_clamped = POS_MAX;
    end else if (target_x < POS_MIN_X) begin
      target_clamped = POS_MIN;
    end else begin
      target_clamped = POS_WIDTH'(target_x);
    end
  end

  // Timer loads saturate at the timer's all-ones value.
  always_comb begin
    hp_x     = TEX_W'(cfg.half_period);
    gap_x    = TEX_W'(cfg.home_gap);
    hp_load  = (hp_x > TMR_MAX_X) ? {TIMER_WIDTH{1'b1}} : TIMER_WIDTH'(hp_x);
    gap_load = (gap_x > TMR_MAX_X) ? {TIMER_WIDTH{1'b1}} : TIMER_WIDTH'(gap_x);
  end

  assign timer_dec = (timer_r != '0) ? timer_r - 1'b1 : timer_r;

  // Next state for one request.
  always_comb begin
    phase_nxt = phase_r;
    fresh_nxt = fresh_r;
    pos_nxt   = pos_r;
    goal_nxt  = goal_r;
    mode_nxt  = mode_r;
    sub_nxt   = sub_r;
    timer_nxt = timer_r;
    do_step   = 1'b0;
    step_fwd  = 1'b0;
    ignored   = 1'b0;

    if (opcode == sap_pkg::OP_GOTO || opcode == sap_pkg::OP_HOME) begin
      // Commands start only from idle.
      if (mode_r != sap_pkg::MODE_IDLE) begin
        ignored = 1'b1;
      end else if (opcode == sap_pkg::OP_GOTO) begin
        goal_nxt = target_clamped;
        if (target_clamped != pos_r) begin
          mode_nxt = sap_pkg::MODE_GOTO;
          do_step  = 1'b1;
          step_fwd = pos_r < target_clamped;
        end
      end else if (limit_switch) begin
        mode_nxt = sap_pkg::MODE_HOME;
        do_step  = 1'b1;
      end else begin
        pos_nxt = '0;
      end
    end else if (mode_r != sap_pkg::MODE_IDLE) begin
      // A tick while busy: count down and end the sub-step at zero.
      timer_nxt = timer_dec;
      if (timer_dec == '0) begin
        priority if (sub_r == sap_pkg::SUB_ENERGIZED) begin
          sub_nxt   = sap_pkg::SUB_OFF;
          timer_nxt = hp_load;
        end else if (mode_r == sap_pkg::MODE_GOTO) begin
          if (pos_r == goal_r) begin
            mode_nxt = sap_pkg::MODE_IDLE;
          end else begin
            do_step  = 1'b1;
            step_fwd = pos_r < goal_r;
          end
        end else if (sub_r == sap_pkg::SUB_OFF) begin
          sub_nxt   = sap_pkg::SUB_GAP;
          timer_nxt = gap_load;
        end else if (limit_switch) begin
          do_step = 1'b1;
        end else begin
          pos_nxt  = '0;
          mode_nxt = sap_pkg::MODE_IDLE;
        end
      end
    end

    // Start of a step: move the phase and the saturating position.
    if (do_step) begin
      if (step_fwd) begin
        phase_nxt = fresh_r ? sap_pkg::PHASE_FRESH_FWD : phase_r + 1'b1;
        pos_nxt   = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
      end else begin
        phase_nxt = fresh_r ? sap_pkg::PHASE_FRESH_BWD : phase_r - 1'b1;
        pos_nxt   = (pos_r == POS_MIN) ? pos_r : pos_r - 1'b1;
      end
      fresh_nxt = 1'b0;
      sub_nxt   = sap_pkg::SUB_ENERGIZED;
      timer_nxt = hp_load;
    end
  end

  // State registers advance once per processed request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      fresh_r <= 1'b1;
      pos_r   <= '0;
      goal_r  <= '0;
      mode_r  <= sap_pkg::MODE_IDLE;
      sub_r   <= sap_pkg::SUB_ENERGIZED;
      timer_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      fresh_r <= fresh_nxt;
      pos_r   <= pos_nxt;
      goal_r  <= goal_nxt;
      mode_r  <= mode_nxt;
      sub_r   <= sub_nxt;
      timer_r <= timer_nxt;
    end
  end

  // Result from the updated state: the coil pattern comes from the table.
  always_comb begin
    pos_ext                 = EXT_W'(pos_nxt);
    result.current_position = pos_ext[FW-1:0];
    result.busy_res         = mode_nxt != sap_pkg::MODE_IDLE;
    result.command_ignored  = ignored;
    if (mode_nxt != sap_pkg::MODE_IDLE && sub_nxt == sap_pkg::SUB_ENERGIZED) begin
      result.coil_drive = cfg.coil_table[{phase_nxt, 2'b00} +: sap_pkg::COIL_W];
    end else begin
      result.coil_drive = '0;
    end
  end

endmodule

FILE: hw/rtl/stepper_axis_positioner.sv
// Top level of the stepper axis positioner: request register, axis core,
// result register. Depends on sap_pkg, sap_in_if, sap_out_if, sap_cfg_regs, sap_axis_core.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+---------------------------------------
//  in_chan  | in        | valid/ready           | opcode, target_position, limit_switch
//  out_chan | out       | valid/ready           | coil_drive, current_position, busy_res,
//           |           |                       | command_ignored
//  cfg_*    | in        | cfg_we (no wait)      | cfg_index, cfg_data
//
// One request per cycle is taken while out_chan does not stall; its result passes through
// the request register, then the result register, before it is on out_chan.
// Reset is synchronous on rst_n and clears both stages and the axis state.
// When out_chan stalls, a request still moves into the empty request register,
// and in_chan.ready drops only when both registers hold an item.
module stepper_axis_positioner #(
  parameter int unsigned POS_WIDTH   = sap_pkg::DEF_POS_WIDTH,
  parameter int unsigned TIMER_WIDTH = sap_pkg::DEF_TIMER_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sap_in_if.sink                        in_chan,
  sap_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [sap_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sap_pkg::FIELD_W-1:0]   cfg_data
);

  sap_pkg::sap_cfg_t    cfg;
  sap_pkg::sap_result_t core_res;
  sap_pkg::sap_result_t res_r;

  logic                               in_v_r;
  logic [sap_pkg::OPCODE_W-1:0]       op_r;
  logic signed [sap_pkg::FIELD_W-1:0] tgt_r;
  logic                               lim_r;
  logic                               out_v_r;
  logic                               advance;
  logic                               fire;

  sap_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The result stage can take a new item when empty or being drained.
  assign advance       = !out_v_r || out_chan.ready;
  assign fire          = in_v_r && advance;
  assign in_chan.ready = !in_v_r || advance;

  // Request register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      op_r  <= in_chan.opcode;
      tgt_r <= in_chan.target_position;
      lim_r <= in_chan.limit_switch;
    end
  end

  sap_axis_core #(
    .POS_WIDTH   (POS_WIDTH),
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (fire),
    .opcode          (op_r),
    .target_position (tgt_r),
    .limit_switch    (lim_r),
    .cfg             (cfg),
    .result          (core_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= core_res;
    end
  end

  assign out_chan.valid            = out_v_r;
  assign out_chan.coil_drive       = res_r.coil_drive;
  assign out_chan.current_position = res_r.current_position;
  assign out_chan.busy_res         = res_r.busy_res;
  assign out_chan.command_ignored  = res_r.command_ignored;

  // An ignored command leaves the axis busy.
  a_ignored_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.command_ignored |-> res_r.busy_res)
    else $error("ignored command reported while idle");

  // Coils are driven only while the axis is busy.
  a_coils_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (res_r.coil_drive != '0) |-> res_r.busy_res)
    else $error("coils driven while idle");

  // A request held back by a stalled result stage stays in the request register.
  a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !advance |=> in_v_r && $stable(op_r) && $stable(tgt_r))
    else $error("pending request lost during stall");

endmodule

FILE: bench/sap_axis_sb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the stepper axis positioner bench: an axis predictor that turns each
// accepted request into its expected result, plus the in-order result checker.
// Depends on sap_pkg for field widths, opcodes, mode and sub-step codes and the result struct.
package sap_axis_sb_pkg;
  import sap_pkg::*;

  localparam logic signed [FIELD_W-1:0] POS_TOP    = 16'sh7FFF;
  localparam logic signed [FIELD_W-1:0] POS_BOTTOM = 16'sh8000;
  localparam int unsigned MAX_REPORTS = 25;

  class sap_axis_scoreboard;
    // Shadow copies of the configuration registers.
    logic [FIELD_W-1:0]        half_period;
    logic [FIELD_W-1:0]        gap_ticks;
    logic [FIELD_W-1:0]        coil_patterns;
    // Predicted axis state.
    logic [PHASE_W-1:0]        coil_phase;
    logic                      phase_unset;
    logic signed [FIELD_W-1:0] axis_pos;
    logic signed [FIELD_W-1:0] axis_goal;
    logic [1:0]                axis_mode;
    logic [1:0]                step_part;
    logic [FIELD_W-1:0]        countdown;
    // Results still owed by the block, oldest first.
    sap_result_t               expected_q[$];
    int unsigned               n_requests, n_checked, n_ignored, n_steps, n_errors;

    function new();
      half_period   = RST_HALF_PERIOD;
      gap_ticks     = RST_HOME_GAP;
      coil_patterns = RST_COIL_TABLE;
      coil_phase    = '0;
      phase_unset   = 1'b1;
      axis_pos      = '0;
      axis_goal     = '0;
      axis_mode     = MODE_IDLE;
      step_part     = SUB_ENERGIZED;
      countdown     = '0;
      n_requests    = 0;
      n_checked     = 0;
      n_ignored     = 0;
      n_steps       = 0;
      n_errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
      case (idx)
        CFG_HALF_PERIOD: half_period = data;
        CFG_HOME_GAP:    gap_ticks = data;
        CFG_COIL_TABLE:  coil_patterns = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // One step: move the phase and the position (saturating), then energize.
    function void take_step(logic forward);
      if (forward) begin
        coil_phase = phase_unset ? PHASE_FRESH_FWD : coil_phase + 1'b1;
        if (axis_pos != POS_TOP) axis_pos = axis_pos + 16'sd1;
      end else begin
        coil_phase = phase_unset ? PHASE_FRESH_BWD : coil_phase - 1'b1;
        if (axis_pos != POS_BOTTOM) axis_pos = axis_pos - 16'sd1;
      end
      phase_unset = 1'b0;
      step_part   = SUB_ENERGIZED;
      countdown   = half_period;
      n_steps++;
    endfunction

    // Advance the axis by one accepted request and queue the result it owes.
    function void note_request(logic [OPCODE_W-1:0] op, logic signed [FIELD_W-1:0] target,
                               logic limit);
      sap_result_t owed;
      logic        ignored;
      ignored = 1'b0;
      n_requests++;
      if (op == OP_GOTO || op == OP_HOME) begin
        if (axis_mode != MODE_IDLE) begin
          ignored = 1'b1;
          n_ignored++;
        end else if (op == OP_GOTO) begin
          axis_goal = target;
          if (axis_goal != axis_pos) begin
            axis_mode = MODE_GOTO;
            take_step(axis_pos < axis_goal);
          end
        end else if (limit) begin
          axis_mode = MODE_HOME;
          take_step(1'b0);
        end else begin
          axis_pos = '0;
        end
      end else if (axis_mode != MODE_IDLE) begin
        // Any other code is a tick: count down, then close the current part of the step.
        if (countdown != '0) countdown--;
        if (countdown == '0) begin
          if (step_part == SUB_ENERGIZED) begin
            step_part = SUB_OFF;
            countdown = half_period;
          end else if (axis_mode == MODE_GOTO) begin
            if (axis_pos == axis_goal) axis_mode = MODE_IDLE;
            else take_step(axis_pos < axis_goal);
          end else if (step_part == SUB_OFF) begin
            step_part = SUB_GAP;
            countdown = gap_ticks;
          end else if (limit) begin
            take_step(1'b0);
          end else begin
            axis_pos  = '0;
            axis_mode = MODE_IDLE;
          end
        end
      end
      owed.coil_drive = (axis_mode != MODE_IDLE && step_part == SUB_ENERGIZED) ?
                        coil_patterns[COIL_W*coil_phase +: COIL_W] : '0;
      owed.current_position = axis_pos;
      owed.busy_res         = (axis_mode != MODE_IDLE);
      owed.command_ignored  = ignored;
      expected_q.push_back(owed);
    endfunction

    function void compare_field(string field, logic signed [31:0] want,
                                logic signed [31:0] seen);
      if (seen !== want) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t ns: %s mismatch on result %0d, expected %0d, got %0d",
                   $time, field, n_checked, want, seen);
      end
    endfunction

    // Compare one accepted result with the oldest one owed.
    function void check_result(sap_result_t got);
      sap_result_t want;
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t ns: result with no request waiting, expected none, got %h",
                   $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("coil_drive", want.coil_drive, got.coil_drive);
      compare_field("current_position", want.current_position, got.current_position);
      compare_field("busy_res", want.busy_res, got.busy_res);
      compare_field("command_ignored", want.command_ignored, got.command_ignored);
      n_checked++;
    endfunction
  endclass

endpackage

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the stepper axis positioner bench: clock, reset, request and config drivers,
// result monitor and the test sequence. Depends on sap_pkg, sap_in_if, sap_out_if,
// sap_axis_sb_pkg and the stepper_axis_positioner RTL.
module tb_top;
  import sap_pkg::*;
  import sap_axis_sb_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT      = 1_000_000;
  localparam int unsigned RANDOM_REQUESTS  = 600;
  localparam int unsigned SETTLE_CYCLES    = 4;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FIELD_W-1:0]   cfg_data;
  int unsigned          req_idle_pct;
  int unsigned          res_stall_pct;
  int unsigned          cycle_count = 0;
  sap_result_t          observed;
  sap_axis_scoreboard   axis_sb;

  sap_in_if  req_if();
  sap_out_if res_if();

  stepper_axis_positioner uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (res_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, axis_sb.pending());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random stalls, change on the falling edge.
  always @(negedge clk) begin
    res_if.ready <= (res_stall_pct == 0) || ($urandom_range(99) >= res_stall_pct);
  end

  // Check every result accepted at a rising edge.
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      observed.coil_drive       = res_if.coil_drive;
      observed.current_position = res_if.current_position;
      observed.busy_res         = res_if.busy_res;
      observed.command_ignored  = res_if.command_ignored;
      axis_sb.check_result(observed);
    end
  end

  // Present one request, with random idle cycles ahead of it, and wait for acceptance.
  // Called and returning at a falling edge.
  task automatic send_request(input logic [OPCODE_W-1:0] op,
                              input logic signed [FIELD_W-1:0] target, input logic limit);
    while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid           <= 1'b1;
    req_if.opcode          <= op;
    req_if.target_position <= target;
    req_if.limit_switch    <= limit;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    axis_sb.note_request(op, target, limit);
    @(negedge clk);
  endtask

  function automatic logic [OPCODE_W-1:0] tick_code();
    return ($urandom_range(7) == 0) ? OP_SPARE : OP_TICK;
  endfunction

  task automatic send_ticks(input int unsigned count, input logic limit);
    repeat (count) send_request(tick_code(), FIELD_W'($urandom), limit);
  endtask

  task automatic ticks_until_idle(input logic limit);
    while (axis_sb.axis_mode != MODE_IDLE) send_request(tick_code(), FIELD_W'($urandom), limit);
  endtask

  // Hold the sender until every owed result is in, then let the pipeline settle.
  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    while (axis_sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    axis_sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [FIELD_W-1:0] half, input logic [FIELD_W-1:0] gap,
                            input logic [FIELD_W-1:0] patterns);
    wait_for_results();
    write_reg(CFG_HALF_PERIOD, half);
    write_reg(CFG_HOME_GAP, gap);
    write_reg(CFG_COIL_TABLE, patterns);
  endtask

  // One random request shaped by the predicted axis state: mostly short moves and
  // homing runs with ticks to carry them, plus commands thrown at a busy axis.
  task automatic random_request();
    logic [OPCODE_W-1:0]       op;
    logic signed [FIELD_W-1:0] target;
    logic                      limit;
    int                        dest;
    int unsigned               roll;
    roll   = $urandom_range(99);
    op     = tick_code();
    target = FIELD_W'($urandom);
    limit  = 1'($urandom_range(1));
    if (axis_sb.axis_mode == MODE_IDLE) begin
      if (roll < 50) begin
        op   = OP_GOTO;
        dest = int'(axis_sb.axis_pos) + int'($urandom_range(12)) - 6;
        if (dest > 32767) dest = 32767;
        if (dest < -32768) dest = -32768;
        target = dest[FIELD_W-1:0];
      end else if (roll < 75) begin
        op    = OP_HOME;
        limit = ($urandom_range(9) < 7);
      end
    end else if (roll >= 90) begin
      op = $urandom_range(1) ? OP_GOTO : OP_HOME;
    end else if (axis_sb.axis_mode == MODE_HOME) begin
      limit = ($urandom_range(3) != 0);
    end
    send_request(op, target, limit);
  endtask

  initial begin : test_sequence
    int unsigned idle_set [4];
    int unsigned stall_set [4];
    idle_set  = '{0, 48, 0, 28};
    stall_set = '{0, 0, 48, 28};
    axis_sb                = new();
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = CFG_HALF_PERIOD;
    cfg_data               = '0;
    req_if.valid           = 1'b0;
    req_if.opcode          = OP_TICK;
    req_if.target_position = '0;
    req_if.limit_switch    = 1'b0;
    res_if.ready           = 1'b0;
    req_idle_pct           = 0;
    res_stall_pct          = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Idle axis: ticks of both codes, goto to where it stands, home with the switch low.
    send_request(OP_TICK, 16'sh7FFF, 1'b1);
    send_request(OP_SPARE, 16'sh8000, 1'b0);
    send_request(OP_GOTO, 16'sd0, 1'b1);
    send_request(OP_HOME, 16'sd0, 1'b0);

    // First step from a fresh phase under the reset settings; commands while busy.
    send_request(OP_GOTO, $urandom_range(1) ? 16'sd1 : -16'sd1, 1'b0);
    send_request(OP_GOTO, 16'sh7FFF, 1'b0);
    send_request(OP_HOME, 16'sh8000, 1'b1);
    ticks_until_idle(1'b0);
    send_request(OP_HOME, 16'sd0, 1'b1);
    ticks_until_idle(1'b0);

    // Shortest half period with no homing gap, dark coil table, several homing steps.
    set_config(16'd1, 16'd0, 16'h0000);
    send_request(OP_GOTO, 16'sd3, 1'b0);
    ticks_until_idle(1'b1);
    send_request(OP_HOME, 16'sd0, 1'b1);
    send_ticks(10, 1'b1);
    ticks_until_idle(1'b0);

    set_config(16'd2, 16'd1, 16'hFFFF);
    send_request(OP_GOTO, -16'sd4, 1'b0);
    send_request(OP_GOTO, 16'sh8000, 1'b0);
    ticks_until_idle(1'b0);

    // Move a few steps out, then home from there with several backward steps.
    set_config(16'd1, 16'd0, FIELD_W'($urandom));
    send_request(OP_GOTO, 16'sd5, 1'b1);
    ticks_until_idle(1'b1);
    send_request(OP_HOME, 16'sd0, 1'b1);
    send_ticks(12, 1'b1);
    ticks_until_idle(1'b0);

    // Long half period: hold one energized phase, then shorten the off part.
    set_config(16'd40, 16'd3, FIELD_W'($urandom));
    send_request(OP_GOTO, axis_sb.axis_pos + 16'sd1, 1'b0);
    send_ticks(39, 1'b0);
    set_config(16'd1, 16'd3, FIELD_W'($urandom));
    ticks_until_idle(1'b0);

    // Long homing gap.
    set_config(16'd1, 16'd120, FIELD_W'($urandom));
    send_request(OP_HOME, 16'sd0, 1'b1);
    ticks_until_idle(1'b0);

    // Random traffic over the idling mixes, two settings per mix.
    for (int ph = 0; ph < 4; ph++) begin
      for (int part = 0; part < 2; part++) begin
        set_config(FIELD_W'($urandom_range(4, 1)), FIELD_W'($urandom_range(4)),
                   FIELD_W'($urandom));
        req_idle_pct  = idle_set[ph];
        res_stall_pct = stall_set[ph];
        repeat (RANDOM_REQUESTS / 8) random_request();
      end
    end

    wait_for_results();
    $display("Run covered %0d requests (%0d commands refused while busy), %0d axis steps,",
             axis_sb.n_requests, axis_sb.n_ignored, axis_sb.n_steps);
    $display("%0d results checked, half periods 1 to 65 and homing gaps 0 to 250.",
             axis_sb.n_checked);
    if (axis_sb.n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
